>>> rtl/assert_macros.svh
// assertion macros used by the checker file ffa_chk.sv
// depends on nothing; each macro expands to one labeled concurrent assertion
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is asserted
`define ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("checker assertion failed");

// next-cycle implication, disabled while reset is asserted
`define ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("checker assertion failed");

`endif

>>> rtl/ffa_pkg.sv
// types, codes and helper functions of the first-fit allocator
// depends on nothing
`default_nettype none

package ffa_pkg;

    // internal arithmetic width: arena end plus the largest header size
    localparam int VW = 18;

    localparam logic [VW-1:0] HDR       = VW'(3);
    localparam logic [VW-1:0] MIN_SPLIT = VW'(4);

    // command codes
    localparam logic CMD_ALLOC = 1'b0;
    localparam logic CMD_FREE  = 1'b1;

    // status codes
    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_ZERO_SIZE = 3'd1;
    localparam logic [2:0] ST_TOO_LARGE = 3'd2;
    localparam logic [2:0] ST_NO_SPACE  = 3'd3;
    localparam logic [2:0] ST_BAD_PTR   = 3'd4;

    typedef enum logic [4:0] {
        S_IDLE,
        S_H0,
        S_H1,
        S_H2,
        S_H3,
        S_W0,
        S_W1,
        S_W2,
        S_WF,
        S_A_EVAL,
        S_A_SPLIT,
        S_F_EVAL,
        S_F_CHK,
        S_F_ZERO,
        S_M_START,
        S_M1,
        S_M2,
        S_M_END,
        S_FIN
    } t_state;

    // one result transaction
    typedef struct packed {
        logic [2:0]  status;
        logic [11:0] data_offset;
        logic [11:0] granted_size;
    } t_res;

    // arena memory access from the sequencer
    typedef struct packed {
        logic [VW-1:0] raddr;
        logic          we;
        logic [VW-1:0] waddr;
        logic [7:0]    wdata;
    } t_mem_req;

    // size split into quotient and remainder of 255
    typedef struct packed {
        logic [7:0] q;
        logic [7:0] r;
    } t_qr;

    // size = q * 255 + r
    function automatic logic [VW-1:0] hsize(input logic [7:0] q, input logic [7:0] r);
        logic [VW-1:0] qq;
        qq = VW'(q);
        return (qq << 8) - qq + VW'(r);
    endfunction

    // divide by 255 through two folds of 256 = 255 + 1
    function automatic t_qr div255(input logic [VW-1:0] s);
        logic [VW-9:0] a;
        logic [VW-7:0] t1;
        logic [VW-9:0] c;
        logic [8:0]    t2;
        logic [VW-8:0] q;
        t_qr           res;
        a  = s[VW-1:8];
        t1 = (VW-6)'(a) + (VW-6)'(s[7:0]);
        c  = (VW-8)'(t1[VW-7:8]);
        t2 = 9'(c) + 9'(t1[7:0]);
        q  = (VW-7)'(a) + (VW-7)'(c);
        if (t2 >= 9'd255) begin
            q     = q + (VW-7)'(1);
            res.r = 8'(t2 - 9'd255);
        end else begin
            res.r = t2[7:0];
        end
        res.q = q[7:0];
        return res;
    endfunction

endpackage

`default_nettype wire

>>> rtl/ffa_mem.sv
// byte arena memory with one read and one write port and a clearing sweep
// depends on ffa_pkg
`default_nettype none

module ffa_mem
    import ffa_pkg::*;
#(
    parameter int ARENA_SIZE = 4096
) (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire t_mem_req i_req,
    output logic [7:0]    o_rdata,
    output logic          o_busy
);

    localparam int AW = $clog2(ARENA_SIZE);
    localparam logic [VW-1:0] L_ARENA = VW'(ARENA_SIZE);
    localparam logic [AW-1:0] L_LAST  = AW'(ARENA_SIZE - 1);

    logic [7:0]    r_mem [ARENA_SIZE];
    logic [7:0]    r_rdata;
    logic          r_oob;
    logic          r_clr;
    logic [AW-1:0] r_clr_addr;

    // clearing sweep after reset, one byte per cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr      <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_clr) begin
            r_clr_addr <= r_clr_addr + AW'(1);
            if (r_clr_addr == L_LAST) begin
                r_clr <= 1'b0;
            end
        end
    end

    // write port, out-of-range writes dropped
    always_ff @(posedge i_clk) begin
        if (r_clr) begin
            r_mem[r_clr_addr] <= 8'd0;
        end else if (i_req.we && (i_req.waddr < L_ARENA)) begin
            r_mem[i_req.waddr[AW-1:0]] <= i_req.wdata;
        end
    end

    // registered read, out-of-range reads give zero
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_req.raddr[AW-1:0]];
        r_oob   <= (i_req.raddr >= L_ARENA);
    end

    assign o_rdata = r_oob ? 8'd0 : r_rdata;
    assign o_busy  = r_clr;

endmodule

`default_nettype wire

>>> rtl/ffa_ctrl.sv
// sequencer that walks the header chain and rewrites headers in the arena
// depends on ffa_pkg
`default_nettype none

module ffa_ctrl
    import ffa_pkg::*;
#(
    parameter int ARENA_SIZE = 4096
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_ready,
    input  wire logic        i_cmd,
    input  wire logic [11:0] i_request_size,
    input  wire logic [11:0] i_block_offset,
    input  wire logic        i_mem_busy,
    input  wire logic [7:0]  i_rdata,
    output t_mem_req         o_mem,
    output logic             o_res_valid,
    input  wire logic        i_res_take,
    output t_res             o_res
);

    localparam logic [VW-1:0] L_ARENA = VW'(ARENA_SIZE);
    localparam logic [VW-1:0] L_WALK  = VW'(ARENA_SIZE - 5);
    localparam logic [VW-1:0] L_LIMIT = VW'(ARENA_SIZE - 3);

    t_state        r_state, n_state;
    t_state        r_fret, n_fret;
    t_state        r_wret, n_wret;
    logic [VW-1:0] r_faddr, n_faddr;
    logic [VW-1:0] r_wbase, n_wbase;
    logic [VW-1:0] r_wsize, n_wsize;
    logic          r_wflag, n_wflag;
    logic [VW-1:0] r_i, n_i;
    logic [VW-1:0] r_h, n_h;
    logic [VW-1:0] r_bs, n_bs;
    logic [VW-1:0] r_size, n_size;
    logic [11:0]   r_ptr, n_ptr;
    logic [7:0]    r_flag, n_flag;
    logic [7:0]    r_q, n_q;
    logic [7:0]    r_r, n_r;
    logic          r_flag_i0, n_flag_i0;
    logic          r_merge_i, n_merge_i;
    t_res          r_res, n_res;

    logic [VW-1:0] hs;
    logic          a_free;
    logic [VW-1:0] a_bs;
    logic [VW-1:0] a_end;
    logic [VW-1:0] f_nb;
    logic [VW-1:0] m_nb;
    t_qr           qr;

    // header arithmetic on the fetched header
    assign hs     = hsize(r_q, r_r);
    assign a_free = (hs == '0) || (r_flag == 8'd0);
    assign a_bs   = (hs == '0) ? (L_ARENA - r_i - HDR) : hs;
    assign a_end  = r_i + HDR + a_bs;
    assign f_nb   = r_i + hs + HDR;
    assign m_nb   = r_h + hs + HDR;
    assign qr     = div255(r_wsize);

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_merge_i <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_merge_i <= n_merge_i;
        end
    end

    // working registers
    always_ff @(posedge i_clk) begin
        r_fret    <= n_fret;
        r_wret    <= n_wret;
        r_faddr   <= n_faddr;
        r_wbase   <= n_wbase;
        r_wsize   <= n_wsize;
        r_wflag   <= n_wflag;
        r_i       <= n_i;
        r_h       <= n_h;
        r_bs      <= n_bs;
        r_size    <= n_size;
        r_ptr     <= n_ptr;
        r_flag    <= n_flag;
        r_q       <= n_q;
        r_r       <= n_r;
        r_flag_i0 <= n_flag_i0;
        r_res     <= n_res;
    end

    // next state and memory accesses
    always_comb begin
        n_state   = r_state;
        n_fret    = r_fret;
        n_wret    = r_wret;
        n_faddr   = r_faddr;
        n_wbase   = r_wbase;
        n_wsize   = r_wsize;
        n_wflag   = r_wflag;
        n_i       = r_i;
        n_h       = r_h;
        n_bs      = r_bs;
        n_size    = r_size;
        n_ptr     = r_ptr;
        n_flag    = r_flag;
        n_q       = r_q;
        n_r       = r_r;
        n_flag_i0 = r_flag_i0;
        n_merge_i = r_merge_i;
        n_res     = r_res;
        o_mem       = '0;
        o_ready     = 1'b0;
        o_res_valid = 1'b0;

        case (r_state)
            S_IDLE: begin
                o_ready = !i_mem_busy;
                if (i_valid && !i_mem_busy) begin
                    n_size = VW'(i_request_size);
                    n_ptr  = i_block_offset;
                    n_i    = '0;
                    n_res  = '{status: ST_OK, data_offset: 12'd0, granted_size: 12'd0};
                    n_faddr = '0;
                    if (i_cmd == CMD_ALLOC) begin
                        if (i_request_size == 12'd0) begin
                            n_res.status = ST_ZERO_SIZE;
                            n_state      = S_FIN;
                        end else if (VW'(i_request_size) > L_LIMIT) begin
                            n_res.status = ST_TOO_LARGE;
                            n_state      = S_FIN;
                        end else begin
                            n_fret  = S_A_EVAL;
                            n_state = S_H0;
                        end
                    end else begin
                        if (i_block_offset == 12'd0) begin
                            n_state = S_FIN;
                        end else if (VW'(i_block_offset) == HDR) begin
                            n_fret  = S_F_ZERO;
                            n_state = S_H0;
                        end else begin
                            n_fret  = S_F_EVAL;
                            n_state = S_H0;
                        end
                    end
                end
            end

            // header fetch: flag, quotient, remainder
            S_H0: begin
                o_mem.raddr = r_faddr;
                n_state     = S_H1;
            end
            S_H1: begin
                o_mem.raddr = r_faddr + VW'(1);
                n_flag      = i_rdata;
                n_state     = S_H2;
            end
            S_H2: begin
                o_mem.raddr = r_faddr + VW'(2);
                n_q         = i_rdata;
                n_state     = S_H3;
            end
            S_H3: begin
                n_r     = i_rdata;
                n_state = r_fret;
            end

            // header write: flag, quotient, remainder
            S_W0: begin
                o_mem.we    = 1'b1;
                o_mem.waddr = r_wbase;
                o_mem.wdata = {7'd0, r_wflag};
                n_state     = S_W1;
            end
            S_W1: begin
                o_mem.we    = 1'b1;
                o_mem.waddr = r_wbase + VW'(1);
                o_mem.wdata = qr.q;
                n_state     = S_W2;
            end
            S_W2: begin
                o_mem.we    = 1'b1;
                o_mem.waddr = r_wbase + VW'(2);
                o_mem.wdata = qr.r;
                n_state     = r_wret;
            end
            // flag byte only, cleared
            S_WF: begin
                o_mem.we    = 1'b1;
                o_mem.waddr = r_wbase;
                o_mem.wdata = 8'd0;
                n_state     = r_wret;
            end

            // allocate walk step
            S_A_EVAL: begin
                if (a_end > L_ARENA) begin
                    n_res.status = ST_NO_SPACE;
                    n_state      = S_FIN;
                end else if (a_free && (a_bs >= r_size)) begin
                    n_res.data_offset = 12'(r_i + HDR);
                    n_wbase = r_i;
                    n_wflag = 1'b1;
                    n_bs    = a_bs;
                    n_state = S_W0;
                    if ((a_bs - r_size) >= MIN_SPLIT) begin
                        n_wsize            = r_size;
                        n_res.granted_size = 12'(r_size);
                        n_wret             = S_A_SPLIT;
                    end else begin
                        n_wsize            = a_bs;
                        n_res.granted_size = 12'(a_bs);
                        n_wret             = S_FIN;
                    end
                end else begin
                    n_i = a_end;
                    if (a_end < L_WALK) begin
                        n_faddr = a_end;
                        n_state = S_H0;
                    end else begin
                        n_res.status = ST_NO_SPACE;
                        n_state      = S_FIN;
                    end
                end
            end
            // header of the free remainder
            S_A_SPLIT: begin
                n_wbase = r_i + HDR + r_size;
                n_wflag = 1'b0;
                n_wsize = r_bs - r_size - HDR;
                n_wret  = S_FIN;
                n_state = S_W0;
            end

            // free walk step
            S_F_EVAL: begin
                if (f_nb >= L_ARENA) begin
                    n_res.status = ST_BAD_PTR;
                    n_state      = S_FIN;
                end else if ((f_nb + HDR) == VW'(r_ptr)) begin
                    n_flag_i0 = (r_flag == 8'd0);
                    n_h       = f_nb;
                    n_faddr   = f_nb;
                    n_fret    = S_F_CHK;
                    n_state   = S_H0;
                end else begin
                    n_i = f_nb;
                    if (f_nb < L_WALK) begin
                        n_faddr = f_nb;
                        n_state = S_H0;
                    end else begin
                        n_res.status = ST_BAD_PTR;
                        n_state      = S_FIN;
                    end
                end
            end
            S_F_CHK: begin
                if (r_flag != 8'd1) begin
                    n_res.status = ST_BAD_PTR;
                    n_state      = S_FIN;
                end else begin
                    n_merge_i = r_flag_i0;
                    n_wbase   = r_h;
                    n_wret    = S_M_START;
                    n_state   = S_WF;
                end
            end
            // free of the first block
            S_F_ZERO: begin
                if (r_flag == 8'd0) begin
                    n_res.status = ST_BAD_PTR;
                    n_state      = S_FIN;
                end else begin
                    n_h       = '0;
                    n_merge_i = 1'b0;
                    n_wbase   = '0;
                    n_wret    = S_M_START;
                    n_state   = S_WF;
                end
            end

            // merge a free right neighbour into block r_h
            S_M_START: begin
                n_faddr = r_h;
                n_fret  = S_M1;
                n_state = S_H0;
            end
            S_M1: begin
                n_bs = hs;
                if (m_nb < L_WALK) begin
                    n_faddr = m_nb;
                    n_fret  = S_M2;
                    n_state = S_H0;
                end else begin
                    n_state = S_M_END;
                end
            end
            S_M2: begin
                if (r_flag == 8'd0) begin
                    n_wbase = r_h;
                    n_wflag = 1'b0;
                    n_wsize = r_bs + HDR + hs;
                    n_wret  = S_M_END;
                    n_state = S_W0;
                end else begin
                    n_state = S_M_END;
                end
            end
            // left neighbour next when it is free
            S_M_END: begin
                if (r_merge_i) begin
                    n_merge_i = 1'b0;
                    n_h       = r_i;
                    n_state   = S_M_START;
                end else begin
                    n_state = S_FIN;
                end
            end

            // hand the result to the output register
            S_FIN: begin
                o_res_valid = 1'b1;
                if (i_res_take) begin
                    n_state = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_res = r_res;

endmodule

`default_nettype wire

>>> rtl/first_fit_heap_allocator_core.sv
// Allocate: walks the header chain, then writes one header, or two when the block is split;
// free: walks the header chain, clears one flag byte, then up to 2 merges with free neighbours.
// Rejected requests and null frees skip the header walk.
// Requests: one transaction at a time, set by the header walk on the single arena read port.
// Reset: synchronous, active low; a clearing pass over the whole arena follows, o_stall high.
`default_nettype none

module first_fit_heap_allocator_core
    import ffa_pkg::*;
#(
    parameter int ARENA_SIZE = 4096
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_stall,
    input  wire logic        i_cmd,
    input  wire logic [11:0] i_request_size,
    input  wire logic [11:0] i_block_offset,
    output logic             o_valid,
    input  wire logic        i_stall,
    output logic [2:0]       o_status,
    output logic [11:0]      o_data_offset,
    output logic [11:0]      o_granted_size
);

    t_mem_req   mem_req;
    logic [7:0] mem_rdata;
    logic       mem_busy;
    logic       ready;
    logic       res_valid;
    logic       res_take;
    t_res       res;
    logic       r_ovalid;
    t_res       r_out;

    ffa_mem #(
        .ARENA_SIZE(ARENA_SIZE)
    ) u_mem (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (mem_req),
        .o_rdata(mem_rdata),
        .o_busy (mem_busy)
    );

    ffa_ctrl #(
        .ARENA_SIZE(ARENA_SIZE)
    ) u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_ready       (ready),
        .i_cmd         (i_cmd),
        .i_request_size(i_request_size),
        .i_block_offset(i_block_offset),
        .i_mem_busy    (mem_busy),
        .i_rdata       (mem_rdata),
        .o_mem         (mem_req),
        .o_res_valid   (res_valid),
        .i_res_take    (res_take),
        .o_res         (res)
    );

    // output register, refilled when empty or being taken
    assign res_take = res_valid && (!r_ovalid || !i_stall);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (res_take) begin
            r_ovalid <= 1'b1;
        end else if (!i_stall) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_take) begin
            r_out <= res;
        end
    end

    assign o_stall        = !ready;
    assign o_valid        = r_ovalid;
    assign o_status       = r_out.status;
    assign o_data_offset  = r_out.data_offset;
    assign o_granted_size = r_out.granted_size;

endmodule

`default_nettype wire

>>> rtl/ffa_chk.sv
// port-level checker for the allocator core, bound to the top level
// depends on ffa_pkg and assert_macros.svh
`default_nettype none
`include "assert_macros.svh"

module ffa_chk
    import ffa_pkg::*;
(
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        i_valid,
    input wire logic        o_stall,
    input wire logic        i_cmd,
    input wire logic [11:0] i_request_size,
    input wire logic [11:0] i_block_offset,
    input wire logic        o_valid,
    input wire logic        i_stall,
    input wire logic [2:0]  o_status,
    input wire logic [11:0] o_data_offset,
    input wire logic [11:0] o_granted_size
);

    // stalled result holds
    `ASSERT_NXT(a_out_hold, i_clk, i_rst_n, o_valid && i_stall, o_valid && $stable(o_status) && $stable(o_data_offset) && $stable(o_granted_size))

    // failures carry no grant
    `ASSERT_IMP(a_fail_zero, i_clk, i_rst_n, o_valid && (o_status != ST_OK), (o_data_offset == 12'd0) && (o_granted_size == 12'd0))

    // a granted area is never empty
    `ASSERT_IMP(a_grant_size, i_clk, i_rst_n, o_valid && (o_data_offset != 12'd0), (o_status == ST_OK) && (o_granted_size != 12'd0))

    // one transaction at a time
    `ASSERT_NXT(a_busy_after, i_clk, i_rst_n, i_valid && !o_stall, o_stall)

endmodule

bind first_fit_heap_allocator_core ffa_chk u_chk (.*);

`default_nettype wire

>>> tb/first_fit_heap_allocator_core_tb.sv
// testbench of the first-fit heap allocator core: directed and random allocate/free traffic
// depends on ffa_pkg and first_fit_heap_allocator_core; predicts results from its own arena copy
`default_nettype none

module first_fit_heap_allocator_core_tb;
    import ffa_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int ARENA = 4096;

    // arena predictor
    class arena_scoreboard;
        byte unsigned mem [ARENA];
        t_res pending[$];
        int errors;
        int checked;
        int n_ok, n_fail;

        function new();
            foreach (mem[k]) mem[k] = 0;
            errors = 0;
            checked = 0;
            n_ok = 0;
            n_fail = 0;
        endfunction

        function int unsigned rd(int unsigned a);
            return (a < ARENA) ? mem[a] : 0;
        endfunction

        function void wr(int unsigned a, int unsigned v);
            if (a < ARENA) mem[a] = v[7:0];
        endfunction

        function int unsigned blk_size(int unsigned h);
            return rd(h + 1) * 255 + rd(h + 2);
        endfunction

        function void set_hdr(int unsigned h, int unsigned flag, int unsigned sz);
            wr(h, flag);
            wr(h + 1, sz / 255);
            wr(h + 2, sz % 255);
        endfunction

        function void join_next(int unsigned h);
            int unsigned bs, nb;
            bs = blk_size(h);
            nb = h + bs + 3;
            if (nb < ARENA - 5 && rd(nb) == 0) set_hdr(h, rd(h), bs + 3 + blk_size(nb));
        endfunction

        function t_res allocate(int unsigned sz);
            t_res r;
            int unsigned i, bs;
            bit is_free;
            r = '0;
            if (sz == 0) begin
                r.status = ST_ZERO_SIZE;
                return r;
            end
            if (sz > ARENA - 3) begin
                r.status = ST_TOO_LARGE;
                return r;
            end
            i = 0;
            while (i < ARENA - 5) begin
                bs = blk_size(i);
                is_free = (rd(i) == 0);
                if (bs == 0) begin
                    bs = ARENA - i - 3;
                    is_free = 1;
                end
                if (i + 3 + bs > ARENA) break;
                if (is_free && bs >= sz) begin
                    if (bs - sz >= 4) begin
                        set_hdr(i, 1, sz);
                        set_hdr(i + 3 + sz, 0, bs - sz - 3);
                        r.granted_size = 12'(sz);
                    end else begin
                        set_hdr(i, 1, bs);
                        r.granted_size = 12'(bs);
                    end
                    r.data_offset = 12'(i + 3);
                    r.status = ST_OK;
                    return r;
                end
                i += bs + 3;
            end
            r.status = ST_NO_SPACE;
            return r;
        endfunction

        function logic [2:0] release_block(int unsigned ptr);
            int unsigned i, nb;
            if (ptr == 0) return ST_OK;
            if (ptr == 3) begin
                if (rd(0) == 0) return ST_BAD_PTR;
                wr(0, 0);
                join_next(0);
                return ST_OK;
            end
            i = 0;
            while (i < ARENA - 5) begin
                nb = i + blk_size(i) + 3;
                if (nb >= ARENA) return ST_BAD_PTR;
                if (nb + 3 == ptr) begin
                    if (rd(nb) != 1) return ST_BAD_PTR;
                    wr(nb, 0);
                    join_next(nb);
                    if (rd(i) == 0) join_next(i);
                    return ST_OK;
                end
                i = nb;
            end
            return ST_BAD_PTR;
        endfunction

        // note an accepted request, return the expected result
        function t_res note_request(logic cmd, logic [11:0] sz, logic [11:0] ptr);
            t_res r;
            if (cmd == CMD_ALLOC) r = allocate(sz);
            else begin
                r = '0;
                r.status = release_block(ptr);
            end
            if (r.status == ST_OK) n_ok++;
            else n_fail++;
            pending.push_back(r);
            return r;
        endfunction

        // compare one result against the oldest expectation
        function void check_result(t_res got);
            t_res exp;
            checked++;
            if (pending.size() == 0) begin
                report("result with nothing expected", 0, 0);
                return;
            end
            exp = pending.pop_front();
            if (got.status != exp.status) report("status", exp.status, got.status);
            if (got.data_offset != exp.data_offset)
                report("data_offset", exp.data_offset, got.data_offset);
            if (got.granted_size != exp.granted_size)
                report("granted_size", exp.granted_size, got.granted_size);
        endfunction

        function void report(string what, int exp_v, int got_v);
            errors++;
            if (errors <= 30)
                $display("MISMATCH %s: expected %0d got %0d (result %0d)",
                    what, exp_v, got_v, checked);
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic        cmd;
    logic [11:0] request_size;
    logic [11:0] block_offset;
    logic        out_valid;
    logic        out_stall;
    logic [2:0]  status;
    logic [11:0] data_offset;
    logic [11:0] granted_size;

    arena_scoreboard sb;
    int unsigned live[$];
    bit hold_out;
    bit hold_go;

    first_fit_heap_allocator_core #(.ARENA_SIZE(ARENA)) DUT (
        .i_clk(clk),
        .i_rst_n(rst_n),
        .i_valid(in_valid),
        .o_stall(in_stall),
        .i_cmd(cmd),
        .i_request_size(request_size),
        .i_block_offset(block_offset),
        .o_valid(out_valid),
        .i_stall(out_stall),
        .o_status(status),
        .o_data_offset(data_offset),
        .o_granted_size(granted_size)
    );

    always begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // random gap length, mostly short with the odd long one
    function automatic int gap_len();
        int p;
        p = $urandom_range(0, 99);
        if (p < 40) return 0;
        if (p < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    // send one transaction and update the predictor on acceptance
    task automatic send(logic c, logic [11:0] sz, logic [11:0] ptr);
        t_res r;
        int g;
        g = gap_len();
        if (g != 0) begin
            in_valid <= 1'b0;
            repeat (g) @(posedge clk);
        end
        in_valid <= 1'b1;
        cmd <= c;
        request_size <= sz;
        block_offset <= ptr;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        r = sb.note_request(c, sz, ptr);
        if (c == CMD_ALLOC && r.status == ST_OK) live.push_back(r.data_offset);
        if (c == CMD_FREE) begin
            foreach (live[k]) if (live[k] == ptr) begin
                live.delete(k);
                break;
            end
        end
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (sb.pending.size() != 0) @(posedge clk);
        repeat (200) @(posedge clk);
    endtask

    task automatic random_item();
        int p, k;
        p = $urandom_range(0, 99);
        if (p < 45) send(CMD_ALLOC, 12'($urandom_range(1, 120)), 12'($urandom));
        else if (p < 50) send(CMD_ALLOC, 12'($urandom), 12'($urandom));
        else if (p < 85 && live.size() != 0) begin
            k = $urandom_range(0, live.size() - 1);
            send(CMD_FREE, 12'($urandom), 12'(live[k]));
        end else if (p < 92) send(CMD_FREE, 12'($urandom), 12'($urandom));
        else send(CMD_FREE, 12'($urandom), 12'(3 + $urandom_range(0, 2)));
    endtask

    // receiver: random stalls, or a long hold-off on request
    always @(posedge clk) begin
        if (!rst_n) out_stall <= 1'b0;
        else if (hold_out) out_stall <= 1'b1;
        else out_stall <= ($urandom_range(0, 99) < 25);
    end

    always @(posedge clk) begin
        if (rst_n && out_valid && !out_stall)
            sb.check_result('{status, data_offset, granted_size});
    end

    initial begin
        #200ms;
        $display("Verification failed");
        $finish;
    end

    // long receiver hold-off counted here while the sender keeps offering
    initial begin
        wait (hold_go);
        hold_out <= 1'b1;
        repeat (400) @(posedge clk);
        hold_out <= 1'b0;
    end

    initial begin
        sb = new();
        rst_n = 1'b0;
        in_valid = 1'b0;
        cmd = CMD_ALLOC;
        request_size = '0;
        block_offset = '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // directed: special cases and field extremes
        send(CMD_ALLOC, 12'd0, 12'd0);
        send(CMD_ALLOC, 12'd4094, 12'd0);
        send(CMD_ALLOC, 12'd4095, 12'hFFF);
        send(CMD_FREE, 12'd0, 12'd0);
        send(CMD_FREE, 12'hFFF, 12'd3);
        send(CMD_ALLOC, 12'd4093, 12'd0);
        send(CMD_ALLOC, 12'd1, 12'd0);
        send(CMD_FREE, 12'd0, 12'd3);
        send(CMD_FREE, 12'd0, 12'd3);
        send(CMD_ALLOC, 12'd4091, 12'd0);
        send(CMD_FREE, 12'd0, 12'd3);
        send(CMD_ALLOC, 12'd300, 12'd0);
        send(CMD_ALLOC, 12'd10, 12'd0);
        send(CMD_ALLOC, 12'd255, 12'd0);
        send(CMD_FREE, 12'd0, 12'd306);
        send(CMD_FREE, 12'd0, 12'd319);
        send(CMD_FREE, 12'd0, 12'd5);
        send(CMD_FREE, 12'd0, 12'hFFF);
        send(CMD_ALLOC, 12'd8, 12'd0);
        send(CMD_FREE, 12'd0, 12'd3);
        send(CMD_ALLOC, 12'd3000, 12'd0);
        send(CMD_ALLOC, 12'd2000, 12'd0);
        send(CMD_FREE, 12'd0, 12'd3);

        // sender pauses until every expected result has come
        drain();

        // receiver holds off while the sender keeps offering
        hold_go = 1'b1;
        repeat (6) send(CMD_ALLOC, 12'($urandom_range(1, 40)), 12'd0);

        for (int n = 0; n < 2000; n++) random_item();
        // free whatever is left, then tidy up
        while (live.size() != 0) send(CMD_FREE, 12'd0, 12'(live[0]));
        drain();

        $display("covered %0d ok and %0d error transactions, %0d results checked",
            sb.n_ok, sb.n_fail, sb.checked);
        if (sb.errors == 0 && sb.pending.size() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

`default_nettype wire

>>> first_fit_heap_allocator_core.f
+incdir+rtl
rtl/ffa_pkg.sv
rtl/ffa_mem.sv
rtl/ffa_ctrl.sv
rtl/first_fit_heap_allocator_core.sv
rtl/ffa_chk.sv
tb/first_fit_heap_allocator_core_tb.sv
